// ----- design/lrd_pkg.sv -----
// Package for the log record deframer: shared types, codes and length tables.
// Used by lrd_ctrl, lrd_datapath and log_record_deframer.
`default_nettype none
package lrd_pkg;
    localparam int WinLen = 7;
    localparam int MaxRecordBytes = 4096;
    localparam logic [11:0] IdxCap = (MaxRecordBytes - 1 < 4095) ?
        12'(MaxRecordBytes - 1) : 12'd4095;
    localparam logic [7:0] MarkByte = 8'hb0;
    localparam logic [7:0] MarkTail = 8'h0b;
    localparam logic [7:0] TypeText = 8'h07;
    localparam logic [7:0] TypeSysinfo = 8'h0d;
    localparam logic [7:0] TypeLink = 8'h0f;
    localparam logic [11:0] SysinfoCountPos = 12'd28;

    // datapath commands
    typedef enum logic [2:0] {
        CMD_NONE, CMD_PUSH, CMD_DROP1, CMD_DROP3, CMD_CLEAR, CMD_ACCEPT, CMD_REC
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [2:0]  emit_idx;   // window entry to show on output
        logic [7:0]  in_byte;
    } t_ctrl;

    typedef struct packed {
        logic [2:0]  fill;
        logic        head_mark;
        logic        third_tail;
        logic        cand_ok;    // full window is an acceptable record start
        logic        text_short; // text record ends at index 6
        logic        in_record;
        logic [7:0]  cur_type;
        logic [11:0] position;
        logic        rec_last;   // in_byte would end the open record
        logic [7:0]  win_byte;   // window entry selected by emit_idx
        logic [7:0]  win_head;
    } t_stat;

    function automatic logic [7:0] link_len(input logic [3:0] ev);
        case (ev)
            4'd0: link_len = 8'd17;  4'd1: link_len = 8'd21;
            4'd2: link_len = 8'd23;  4'd3: link_len = 8'd26;
            4'd4: link_len = 8'd8;   4'd5: link_len = 8'd31;
            4'd6: link_len = 8'd29;  4'd7: link_len = 8'd12;
            4'd8: link_len = 8'd12;  4'd9: link_len = 8'd12;
            4'd10: link_len = 8'd12; 4'd11: link_len = 8'd12;
            4'd12: link_len = 8'd14; 4'd13: link_len = 8'd36;
            4'd14: link_len = 8'd18;
            default: link_len = 8'd0;
        endcase
    endfunction

    // total length including type and seq, zero for types without a fixed size
    function automatic logic [7:0] fixed_total(input logic [7:0] t);
        case (t)
            8'h01: fixed_total = 8'd111;
            8'h02, 8'h15: fixed_total = 8'd47;
            8'h03, 8'h04, 8'h06, 8'h0c: fixed_total = 8'd10;
            8'h05: fixed_total = 8'd51;
            8'h08, 8'h09, 8'h0a: fixed_total = 8'd14;
            8'h0b: fixed_total = 8'd22;
            8'h10: fixed_total = 8'd24;
            8'h12: fixed_total = 8'd18;
            8'h13: fixed_total = 8'd19;
            8'h14: fixed_total = 8'd70;
            8'h16: fixed_total = 8'd8;
            default: fixed_total = 8'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

// ----- design/lrd_datapath.sv -----
// Datapath of the log record deframer: lookahead window, candidate check and
// record counters. Driven by lrd_ctrl through lrd_pkg::t_ctrl.
`default_nettype none
module lrd_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  lrd_pkg::t_ctrl     i_ctrl,
    output lrd_pkg::t_stat     o_stat
);
    logic [7:0]  r_win [lrd_pkg::WinLen];
    logic [2:0]  r_fill;
    logic        r_in_record;
    logic [7:0]  r_type;
    logic [11:0] r_left;
    logic [11:0] r_pos;
    logic        r_seek;

    logic [7:0]  w_total;
    logic        w_ok;
    logic [11:0] w_left_dec;
    logic [11:0] n_left;
    logic        w_last;

    always_comb begin
        w_total = 8'd0;
        w_ok = (r_win[2] | r_win[3] | r_win[4] | r_win[5]) != 8'd0;
        if (r_win[0] == lrd_pkg::TypeLink) begin
            if (r_win[6] >= 8'd15) w_ok = 1'b0;
            else w_total = 8'd2 + lrd_pkg::link_len(r_win[6][3:0]);
        end else if (r_win[0] != lrd_pkg::TypeText &&
                     r_win[0] != lrd_pkg::TypeSysinfo) begin
            w_total = lrd_pkg::fixed_total(r_win[0]);
            if (w_total == 8'd0) w_ok = 1'b0;
        end
    end

    always_comb begin
        w_left_dec = (r_left != 12'd0) ? r_left - 12'd1 : 12'd0;
        n_left = w_left_dec;
        if (r_type == lrd_pkg::TypeSysinfo && r_pos == lrd_pkg::SysinfoCountPos)
            n_left = 12'({i_ctrl.in_byte, 4'b0} - {4'b0, i_ctrl.in_byte});
        w_last = r_seek ? (i_ctrl.in_byte == 8'd0) : (n_left == 12'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_in_record <= 1'b0;
            r_type <= '0;
            r_left <= '0;
            r_pos <= '0;
            r_seek <= 1'b0;
        end else begin
            case (i_ctrl.cmd)
                lrd_pkg::CMD_PUSH: begin
                    r_win[r_fill] <= i_ctrl.in_byte;
                    r_fill <= r_fill + 3'd1;
                end
                lrd_pkg::CMD_DROP1: begin
                    for (int k = 0; k < lrd_pkg::WinLen - 1; k++)
                        r_win[k] <= r_win[k+1];
                    r_fill <= r_fill - 3'd1;
                end
                lrd_pkg::CMD_DROP3: begin
                    for (int k = 0; k < lrd_pkg::WinLen - 3; k++)
                        r_win[k] <= r_win[k+3];
                    r_fill <= r_fill - 3'd3;
                end
                lrd_pkg::CMD_CLEAR: begin
                    r_fill <= '0;
                    r_in_record <= 1'b0;
                    r_type <= '0;
                    r_left <= '0;
                    r_pos <= '0;
                    r_seek <= 1'b0;
                end
                lrd_pkg::CMD_ACCEPT: begin
                    r_fill <= '0;
                    r_type <= r_win[0];
                    r_pos <= 12'd7;
                    r_seek <= (r_win[0] == lrd_pkg::TypeText);
                    r_in_record <= !(r_win[0] == lrd_pkg::TypeText &&
                                     r_win[6] == 8'd0);
                    if (r_win[0] == lrd_pkg::TypeText) r_left <= 12'd0;
                    else if (r_win[0] == lrd_pkg::TypeSysinfo) r_left <= 12'd22;
                    else r_left <= {4'b0, w_total} - 12'd7;
                end
                lrd_pkg::CMD_REC: begin
                    if (w_last) begin
                        r_in_record <= 1'b0;
                        r_seek <= 1'b0;
                        r_left <= '0;
                        r_pos <= '0;
                    end else begin
                        r_left <= n_left;
                        if (r_pos < 12'd4095) r_pos <= r_pos + 12'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.fill = r_fill;
        o_stat.head_mark = r_win[0] == lrd_pkg::MarkByte;
        o_stat.third_tail = r_win[2] == lrd_pkg::MarkTail;
        o_stat.cand_ok = w_ok;
        o_stat.text_short = r_win[0] == lrd_pkg::TypeText && r_win[6] == 8'd0;
        o_stat.in_record = r_in_record;
        o_stat.cur_type = r_type;
        o_stat.position = (r_pos > lrd_pkg::IdxCap) ? lrd_pkg::IdxCap : r_pos;
        o_stat.rec_last = w_last;
        o_stat.win_byte = (i_ctrl.emit_idx < 3'd7) ? r_win[i_ctrl.emit_idx] : 8'd0;
        o_stat.win_head = r_win[0];
    end
endmodule
`default_nettype wire

// ----- design/lrd_ctrl.sv -----
// Controller of the log record deframer: takes beats, scans the window and
// sequences the output beats. Drives lrd_datapath through lrd_pkg types.
`default_nettype none
module lrd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_in_eos,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [29:0]        o_out_data,
    input  lrd_pkg::t_stat     i_stat,
    output lrd_pkg::t_ctrl     o_ctrl
);
    typedef enum logic [1:0] { ST_IDLE, ST_SCAN, ST_EMIT } t_state;

    t_state      r_state;
    logic [2:0]  r_idx;
    logic        r_short;
    logic        r_out_valid;
    logic [29:0] r_out_data;
    logic        w_take;
    logic        w_free;
    logic        w_load;

    // output register free or draining this cycle
    assign w_free = !r_out_valid || i_out_ready;
    assign w_take = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;
    // a new output beat enters the register this cycle
    assign w_load = ((r_state == ST_IDLE) && w_take && i_stat.in_record) ||
                    ((r_state == ST_EMIT) && w_free);

    // pack: type, byte, index, last, aborted
    function automatic logic [29:0] pack(input logic [7:0] t, input logic [7:0] b,
                                         input logic [11:0] i, input logic l,
                                         input logic a);
        pack = {a, l, i, b, t};
    endfunction

    always_comb begin
        o_ctrl.cmd = lrd_pkg::CMD_NONE;
        o_ctrl.emit_idx = r_idx;
        o_ctrl.in_byte = i_in_byte;
        case (r_state)
            ST_IDLE: if (w_take) begin
                if (i_in_eos) o_ctrl.cmd = lrd_pkg::CMD_CLEAR;
                else if (i_stat.in_record) o_ctrl.cmd = lrd_pkg::CMD_REC;
                else o_ctrl.cmd = lrd_pkg::CMD_PUSH;
            end
            ST_SCAN: begin
                if (i_stat.fill == 3'd0) o_ctrl.cmd = lrd_pkg::CMD_NONE;
                else if (i_stat.head_mark) begin
                    if (i_stat.fill >= 3'd3)
                        o_ctrl.cmd = i_stat.third_tail ? lrd_pkg::CMD_DROP3
                                                       : lrd_pkg::CMD_DROP1;
                end else if (i_stat.fill == 3'd7)
                    o_ctrl.cmd = i_stat.cand_ok ? lrd_pkg::CMD_NONE
                                                : lrd_pkg::CMD_DROP1;
            end
            ST_EMIT: if (w_free && r_idx == 3'd6) o_ctrl.cmd = lrd_pkg::CMD_ACCEPT;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx <= '0;
            r_short <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: if (w_take) begin
                    if (i_in_eos) begin
                        if (i_stat.in_record) begin
                            r_out_data <= pack(i_stat.cur_type, 8'd0,
                                               i_stat.position, 1'b1, 1'b1);
                        end
                    end else if (i_stat.in_record) begin
                        r_out_data <= pack(i_stat.cur_type, i_in_byte,
                                           i_stat.position, i_stat.rec_last, 1'b0);
                    end else r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    // stay while a drop is issued; rescan next cycle
                    if (i_stat.fill == 3'd0) r_state <= ST_IDLE;
                    else if (i_stat.head_mark) begin
                        if (i_stat.fill < 3'd3) r_state <= ST_IDLE;
                    end else if (i_stat.fill != 3'd7) r_state <= ST_IDLE;
                    else if (i_stat.cand_ok) begin
                        r_state <= ST_EMIT;
                        r_idx <= 3'd0;
                        r_short <= i_stat.text_short;
                    end
                end
                ST_EMIT: if (w_free) begin
                    r_out_data <= pack(i_stat.win_head, i_stat.win_byte,
                                       {9'd0, r_idx}, r_short && r_idx == 3'd6, 1'b0);
                    if (r_idx == 3'd6) r_state <= ST_IDLE;
                    else r_idx <= r_idx + 3'd1;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/log_record_deframer.sv -----
// Top level of the log record deframer: joins lrd_ctrl and lrd_datapath.
// Depends on lrd_pkg.
`default_nettype none
// Takes the binary log stream one byte per beat and returns the bytes of each
// accepted record with type, index and last flag. A byte inside an open record
// goes straight to the output register. A byte outside a record is pushed into the
// window and then scanned step by step, one drop per step (a three-byte marker skip
// is one step); on accept the seven window bytes go out as output beats. A beat
// with end of stream set clears the block and, inside a record, gives one
// aborted beat. Output sits in a single register; input is taken only while idle
// and that register is empty or draining, so scans and output stalls hold it off.
module log_record_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    input  wire logic        s_axis_tlast,   // end_of_stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // out_byte, byte_index, zero pad
    output logic [15:0]      m_axis_tuser,   // record_type, aborted, zero pad
    output logic             m_axis_tlast    // last_byte
);
    lrd_pkg::t_ctrl w_ctrl;
    lrd_pkg::t_stat w_stat;
    logic [29:0]    w_data;

    lrd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_byte(s_axis_tdata),
        .i_in_eos(s_axis_tlast), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_out_data(w_data), .i_stat(w_stat), .o_ctrl(w_ctrl)
    );

    lrd_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(w_ctrl), .o_stat(w_stat)
    );

    assign m_axis_tuser = {7'd0, w_data[29], w_data[7:0]};
    assign m_axis_tdata = {4'd0, w_data[27:8]};
    assign m_axis_tlast = w_data[28];
endmodule
`default_nettype wire

// ----- bench/tb_log_record_deframer.sv -----
// Self-checking bench for log_record_deframer: random byte streams of framed
// records, noise, markers and end-of-stream beats against an in-bench predictor.
// Depends on lrd_pkg and the design files.
`timescale 1ns / 100ps
`default_nettype none
module tb_log_record_deframer;

    typedef struct {
        logic [7:0] dat;
        logic       eos;
        bit         wait_idle;  // hold this beat until every result has drained
    } t_in_beat;

    typedef struct {
        logic [7:0]  rtype;
        logic [7:0]  dat;
        logic [11:0] idx;
        logic        last;
        logic        abort;
    } t_rec_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [15:0] m_axis_tuser;
    logic        m_axis_tlast;

    log_record_deframer u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    t_in_beat  stream_q[$];
    t_rec_beat record_q[$];
    int        n_errors = 0;

    // predictor state
    logic [7:0]  win[lrd_pkg::WinLen];
    int          win_fill = 0;
    bit          open_rec = 0;
    logic [7:0]  open_type = 8'd0;
    int          remaining = 0;
    int          rec_pos = 0;
    bit          want_nul = 0;

    function automatic int record_total(input logic [7:0] t);
        case (t)
            8'h01: return 111;
            8'h02, 8'h15: return 47;
            8'h03, 8'h04, 8'h06, 8'h0c: return 10;
            8'h05: return 51;
            8'h08, 8'h09, 8'h0a: return 14;
            8'h0b: return 22;
            8'h10: return 24;
            8'h12: return 18;
            8'h13: return 19;
            8'h14: return 70;
            8'h16: return 8;
            default: return 0;
        endcase
    endfunction

    function automatic int link_total(input int ev);
        int lens[15] = '{17, 21, 23, 26, 8, 31, 29, 12, 12, 12, 12, 12, 14, 36, 18};
        return 2 + lens[ev];
    endfunction

    function automatic void emit(input logic [7:0] t, input logic [7:0] d, input int idx,
                                 input logic last, input logic ab);
        t_rec_beat r;
        r.rtype = t;
        r.dat = d;
        r.idx = (idx > int'(lrd_pkg::IdxCap)) ? lrd_pkg::IdxCap : 12'(idx);
        r.last = last;
        r.abort = ab;
        record_q = {record_q, r};
    endfunction

    task automatic shift_window(input int n);
        if (n >= win_fill) begin
            win_fill = 0;
        end else begin
            for (int k = 0; k < win_fill - n; k++) win[k] = win[k + n];
            win_fill -= n;
        end
    endtask

    // full window: accept and emit, or return 0 to reject
    function automatic bit try_accept();
        logic [7:0] t;
        int total;
        t = win[0];
        total = 0;
        if ((win[2] | win[3] | win[4] | win[5]) == 8'd0) return 0;
        if (t == lrd_pkg::TypeLink) begin
            if (win[6] >= 8'd15) return 0;
            total = link_total(win[6]);
        end else if (t != lrd_pkg::TypeText && t != lrd_pkg::TypeSysinfo) begin
            total = record_total(t);
            if (total == 0) return 0;
        end
        open_type = t;
        win_fill = 0;
        if (t == lrd_pkg::TypeText && win[6] == 8'd0) begin
            for (int k = 0; k < lrd_pkg::WinLen; k++)
                emit(t, win[k], k, k == lrd_pkg::WinLen - 1, 1'b0);
            return 1;
        end
        for (int k = 0; k < lrd_pkg::WinLen; k++) emit(t, win[k], k, 1'b0, 1'b0);
        open_rec = 1;
        rec_pos = lrd_pkg::WinLen;
        want_nul = (t == lrd_pkg::TypeText);
        if (t == lrd_pkg::TypeText) remaining = 0;
        else if (t == lrd_pkg::TypeSysinfo)
            remaining = int'(lrd_pkg::SysinfoCountPos) + 1 - lrd_pkg::WinLen;
        else remaining = total - lrd_pkg::WinLen;
        return 1;
    endfunction

    task automatic predict_beat(input logic [7:0] b, input logic eos);
        bit last;
        if (eos) begin
            if (open_rec) emit(open_type, 8'd0, rec_pos, 1'b1, 1'b1);
            win_fill = 0; open_rec = 0; open_type = 8'd0;
            remaining = 0; rec_pos = 0; want_nul = 0;
            return;
        end
        if (open_rec) begin
            if (want_nul) begin
                last = (b == 8'd0);
            end else begin
                if (remaining > 0) remaining--;
                if (open_type == lrd_pkg::TypeSysinfo &&
                    rec_pos == int'(lrd_pkg::SysinfoCountPos))
                    remaining = 15 * b;
                last = (remaining == 0);
            end
            emit(open_type, b, rec_pos, last, 1'b0);
            if (rec_pos < 4095) rec_pos++;
            if (last) begin
                open_rec = 0; want_nul = 0; remaining = 0; rec_pos = 0;
            end
            return;
        end
        win[win_fill] = b;
        win_fill++;
        forever begin
            if (win_fill == 0) return;
            if (win[0] == lrd_pkg::MarkByte) begin
                if (win_fill < 3) return;
                shift_window(win[2] == lrd_pkg::MarkTail ? 3 : 1);
                continue;
            end
            if (win_fill < lrd_pkg::WinLen) return;
            if (try_accept()) return;
            shift_window(1);
        end
    endtask

    // stimulus builders
    int n_stream = 0;

    task automatic put_byte(input logic [7:0] b);
        t_in_beat x;
        x.dat = b; x.eos = 1'b0; x.wait_idle = 0;
        stream_q = {stream_q, x};
        n_stream++;
    endtask

    task automatic put_eos();
        t_in_beat x;
        x.dat = 8'($urandom); x.eos = 1'b1; x.wait_idle = 0;
        stream_q = {stream_q, x};
        n_stream++;
    endtask

    function automatic logic [7:0] nz_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    // kind: 0 fixed, 1 link, 2 sysinfo, 3 text; cut >= 0 stops after that many
    // bytes and ends the stream; text_len is the whole text record length including its NUL
    task automatic put_record(input int kind, input int cut, input int text_len);
        logic [7:0] r[$];
        logic [7:0] fixed_types[17] = '{8'h01, 8'h02, 8'h15, 8'h03, 8'h04, 8'h06,
            8'h0c, 8'h05, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h10, 8'h12, 8'h13, 8'h14, 8'h16};
        logic [31:0] stamp;
        int total;
        int cnt;
        stamp = $urandom;
        if (stamp == 0) stamp = 32'd1;
        case (kind)
            0: r = {r, fixed_types[$urandom_range(0, 16)]};
            1: r = {r, lrd_pkg::TypeLink};
            2: r = {r, lrd_pkg::TypeSysinfo};
            default: r = {r, lrd_pkg::TypeText};
        endcase
        r = {r, 8'($urandom)};
        for (int k = 0; k < 4; k++) r = {r, stamp[8*k +: 8]};
        case (kind)
            0: total = record_total(r[0]);
            1: begin
                cnt = $urandom_range(0, 14);
                total = link_total(cnt);
            end
            2: begin
                cnt = $urandom_range(0, 3);
                total = 29 + 15 * cnt;
            end
            default: total = text_len;
        endcase
        while (r.size() < total) begin
            if (kind == 3) r = {r, (r.size() == total - 1) ? 8'd0 : nz_byte()};
            else if (kind == 1 && r.size() == 6) r = {r, 8'(cnt)};
            else if (kind == 2 && r.size() == 28) r = {r, 8'(cnt)};
            else r = {r, 8'($urandom)};
        end
        foreach (r[k]) begin
            if (cut >= 0 && k >= cut) break;
            put_byte(r[k]);
        end
        if (cut >= 0) put_eos();
    endtask

    // driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        bit nv;
        t_in_beat x;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_beat(s_axis_tdata, s_axis_tlast);
                nv = 0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stream_q.size() > 0 &&
                             !(stream_q[0].wait_idle && record_q.size() > 0)) begin
                    x = stream_q.pop_front();
                    s_axis_tdata <= x.dat;
                    s_axis_tlast <= x.eos;
                    nv = 1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 20);
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // receiver: stall pattern redrawn at random from time to time, one long hold-off
    int rx_cycle = 0;
    int rx_mode = 0;

    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
        if (rx_cycle >= 200 && rx_cycle < 600) m_axis_tready <= 1'b0;
        else case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= $urandom_range(0, 9) != 0;
            default: m_axis_tready <= $urandom_range(0, 4) == 0;
        endcase
    end

    // monitor
    always @(posedge i_clk) begin
        t_rec_beat e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (record_q.size() == 0) begin
                $error("unexpected beat: type %h byte %h", m_axis_tuser[7:0],
                       m_axis_tdata[7:0]);
                n_errors++;
            end else begin
                e = record_q.pop_front();
                if (m_axis_tuser[7:0] !== e.rtype) begin
                    $error("record_type exp %h got %h", e.rtype, m_axis_tuser[7:0]);
                    n_errors++;
                end
                if (m_axis_tdata[7:0] !== e.dat) begin
                    $error("out_byte exp %h got %h", e.dat, m_axis_tdata[7:0]);
                    n_errors++;
                end
                if (m_axis_tdata[19:8] !== e.idx) begin
                    $error("byte_index exp %0d got %0d", e.idx, m_axis_tdata[19:8]);
                    n_errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_byte exp %b got %b", e.last, m_axis_tlast);
                    n_errors++;
                end
                if (m_axis_tuser[8] !== e.abort) begin
                    $error("aborted exp %b got %b", e.abort, m_axis_tuser[8]);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        t_in_beat x;
        int sel;
        // directed: rejects, markers, short text, aborts, partial window
        put_byte(8'hee); put_byte(8'h00); put_byte(8'h00); put_byte(8'h00);
        put_byte(8'h00); put_byte(8'h00); put_byte(8'hff);
        put_byte(8'h03); put_byte(8'h01); put_byte(8'h00); put_byte(8'h00);
        put_byte(8'h00); put_byte(8'h00); put_byte(8'h00);
        put_byte(lrd_pkg::MarkByte); put_byte(8'h55); put_byte(lrd_pkg::MarkTail);
        put_byte(lrd_pkg::MarkByte); put_byte(8'h12); put_byte(8'h34);
        put_byte(lrd_pkg::TypeLink); put_byte(8'h01); put_byte(8'h01); put_byte(8'h00);
        put_byte(8'h00); put_byte(8'h00); put_byte(8'd15);
        put_eos();
        put_record(3, -1, 7);
        put_record(0, 9, 0);
        put_byte(8'h01); put_byte(8'h02); put_eos();
        put_record(1, -1, 0);
        put_record(2, -1, 0);
        x.dat = 8'd0; x.eos = 1'b1; x.wait_idle = 1;
        stream_q = {stream_q, x};
        // random: mostly well-formed records with noise and broken tails
        while (n_stream < 300) begin
            sel = $urandom_range(0, 11);
            if (sel < 4) put_record(0, -1, 0);
            else if (sel == 4) put_record(1, -1, 0);
            else if (sel == 5) put_record(2, -1, 0);
            else if (sel == 6) put_record(3, -1, $urandom_range(7, 40));
            else if (sel == 7) repeat ($urandom_range(1, 5)) put_byte(8'($urandom));
            else if (sel == 8) begin
                put_byte(lrd_pkg::MarkByte); put_byte(8'($urandom));
                put_byte($urandom_range(0, 1) ? lrd_pkg::MarkTail : 8'($urandom));
            end else if (sel == 9) put_eos();
            else put_record($urandom_range(0, 3), $urandom_range(0, 12), 30);
            if ($urandom_range(0, 15) == 0) stream_q[$].wait_idle = 1;
        end
        put_record(0, -1, 0);
        put_eos();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (s_axis_tvalid || stream_q.size() > 0 || record_q.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0 && record_q.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
